### design/mac_learning_table_top_assert.svh
// ----------------------------------------------------------------------------
// mac_learning_table_top_assert.svh
// Assertion macros shared by the MAC learning table modules.
// ----------------------------------------------------------------------------
`ifndef MAC_LEARNING_TABLE_TOP_ASSERT_SVH
`define MAC_LEARNING_TABLE_TOP_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define MLT_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define MLT_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

### design/mlt_pkg.sv
// ----------------------------------------------------------------------------
// mlt_pkg
// Types, constants and codes shared by the MAC learning table modules.
// ----------------------------------------------------------------------------
package mlt_pkg;

  // Default geometry of the table.
  localparam int BUCKET_BITS_DEF = 7;
  localparam int WAYS_DEF        = 4;
  localparam int TIME_BITS_DEF   = 32;

  // Fixed field widths.
  localparam int KEY_W  = 64;
  localparam int MAC_W  = 48;
  localparam int VLAN_W = 16;
  localparam int PORT_W = 32;
  localparam int CFG_W  = 16;
  localparam int AGED_W = 10;
  localparam int HALF_W = 32;

  localparam logic [AGED_W-1:0] AGED_MAX = '1;

  // Hash constants.
  localparam logic [KEY_W-1:0] HASH_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] HASH_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam int               HASH_SHIFT = 33;

  // Register reset values.
  localparam logic [CFG_W-1:0] MIN_PERSIST_RST = 16'd3;
  localparam logic [CFG_W-1:0] EXPIRE_AGE_RST  = 16'd100;
  localparam logic [CFG_W-1:0] SWEEP_INT_RST   = 16'd2;

  // Configuration port geometry.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_MIN_PERSIST = 2'd0,
    REG_EXPIRE_AGE  = 2'd1,
    REG_SWEEP_INT   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_LEARN  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // Steps of one hash round on the shared multiplier.
  typedef enum logic [2:0] {
    HS_NONE = 3'd0,
    HS_XOR  = 3'd1,
    HS_MLO  = 3'd2,
    HS_MMID = 3'd3,
    HS_MHI  = 3'd4
  } hstep_e;

  typedef struct packed {
    cmd_e              command;
    logic [MAC_W-1:0]  mac;
    logic [VLAN_W-1:0] vlan;
    logic [PORT_W-1:0] port;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [PORT_W-1:0] port_out;
    logic              status;
    logic [AGED_W-1:0] aged_count;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] move_hold;
    logic [CFG_W-1:0] expire_age;
    logic [CFG_W-1:0] sweep_interval;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   capture;
    hstep_e hstep;
    logic   round;
    logic   mem_read;
    logic   entry_update;
    logic   time_tick;
    logic   sweep_read;
    logic   sweep_write;
    logic   clear_write;
    logic   emit_tick;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_due;
    logic row_last;
  } ctl_status_t;

endpackage

### design/mac_learning_table_top.sv
// ----------------------------------------------------------------------------
// mac_learning_table_top
// Source-address learning table with aging for a tunnel switch.
//
//   Channel   Signals                          Transfer
//   command   start, busy, item_i              beat when start and !busy
//   result    result_valid_o, result_o         one-cycle strobe, no stall
//   config    psel/penable/pwrite/paddr/...    APB write on access beat
//
// Lookup and learn run two hash rounds of four steps each on one shared
// 32x32 multiplier, then a bucket read and an update. A tick advances the
// time and, when an aging sweep is due, reads and rewrites each of the
// 2^BUCKET_BITS bucket rows in turn before it reports the aged count.
// After reset a clearing pass over all 2^BUCKET_BITS bucket rows holds busy high.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module mac_learning_table_top #(
  parameter int BUCKET_BITS = mlt_pkg::BUCKET_BITS_DEF,
  parameter int WAYS        = mlt_pkg::WAYS_DEF,
  parameter int TIME_BITS   = mlt_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  mlt_pkg::in_item_t              item_i,
  output mlt_pkg::out_item_t             result_o,
  output logic                           result_valid_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mlt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mlt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mlt_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import mlt_pkg::*;

  cfg_t        cfg;
  ctl_cmd_t    ctl_cmd;
  ctl_status_t ctl_status;

  mlt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mlt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (item_i.command),
    .busy     (busy),
    .status_i (ctl_status),
    .cmd_o    (ctl_cmd)
  );

  mlt_dp #(
    .BUCKET_BITS (BUCKET_BITS),
    .WAYS        (WAYS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cfg_i          (cfg),
    .cmd_i          (ctl_cmd),
    .status_o       (ctl_status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

### design/mlt_cfg.sv
// ----------------------------------------------------------------------------
// mlt_cfg
// APB register file holding the aging and persistence settings.
// ----------------------------------------------------------------------------
module mlt_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mlt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mlt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mlt_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output mlt_pkg::cfg_t                  cfg_o
);
  import mlt_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes on the access beat.
  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (idx)
        REG_MIN_PERSIST: cfg_d.move_hold      = pwdata[CFG_W-1:0];
        REG_EXPIRE_AGE:  cfg_d.expire_age     = pwdata[CFG_W-1:0];
        REG_SWEEP_INT:   cfg_d.sweep_interval = pwdata[CFG_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (idx)
      REG_MIN_PERSIST: prdata = APB_DATA_W'(cfg_q.move_hold);
      REG_EXPIRE_AGE:  prdata = APB_DATA_W'(cfg_q.expire_age);
      REG_SWEEP_INT:   prdata = APB_DATA_W'(cfg_q.sweep_interval);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{move_hold:      MIN_PERSIST_RST,
                 expire_age:     EXPIRE_AGE_RST,
                 sweep_interval: SWEEP_INT_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### design/mlt_ctrl.sv
// ----------------------------------------------------------------------------
// mlt_ctrl
// Sequencer for the clearing pass, hashing, table access, time ticks and aging sweeps.
// ----------------------------------------------------------------------------
module mlt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  mlt_pkg::cmd_e        cmd_i,
  output logic                 busy,
  input  mlt_pkg::ctl_status_t status_i,
  output mlt_pkg::ctl_cmd_t    cmd_o
);
  import mlt_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR   = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_HXOR    = 12'b0000_0000_0100,
    S_HMLO    = 12'b0000_0000_1000,
    S_HMMID   = 12'b0000_0001_0000,
    S_HMHI    = 12'b0000_0010_0000,
    S_READ    = 12'b0000_0100_0000,
    S_UPDATE  = 12'b0000_1000_0000,
    S_TICK    = 12'b0001_0000_0000,
    S_SWREAD  = 12'b0010_0000_0000,
    S_SWWRITE = 12'b0100_0000_0000,
    S_TDONE   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   round_q, round_d;

  assign busy = (state_q != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    round_d = round_q;
    cmd_o   = '0;
    cmd_o.round = round_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_write = 1'b1;
        if (status_i.row_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          unique case (cmd_i) inside
            CMD_LOOKUP, CMD_LEARN: begin
              state_d = S_HXOR;
              round_d = 1'b0;
            end
            CMD_TICK: state_d = S_TICK;
            default:  state_d = S_TDONE;
          endcase
        end
      end
      S_HXOR: begin
        cmd_o.hstep = HS_XOR;
        state_d     = S_HMLO;
      end
      S_HMLO: begin
        cmd_o.hstep = HS_MLO;
        state_d     = S_HMMID;
      end
      S_HMMID: begin
        cmd_o.hstep = HS_MMID;
        state_d     = S_HMHI;
      end
      S_HMHI: begin
        cmd_o.hstep = HS_MHI;
        if (round_q) begin
          state_d = S_READ;
        end else begin
          round_d = 1'b1;
          state_d = S_HXOR;
        end
      end
      S_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.entry_update = 1'b1;
        state_d            = S_IDLE;
      end
      S_TICK: begin
        cmd_o.time_tick = 1'b1;
        state_d = status_i.sweep_due ? S_SWREAD : S_TDONE;
      end
      S_SWREAD: begin
        cmd_o.sweep_read = 1'b1;
        state_d          = S_SWWRITE;
      end
      S_SWWRITE: begin
        cmd_o.sweep_write = 1'b1;
        state_d = status_i.row_last ? S_TDONE : S_SWREAD;
      end
      S_TDONE: begin
        cmd_o.emit_tick = 1'b1;
        state_d         = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      round_q <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
    end
  end

endmodule

### design/mlt_dp.sv
// ----------------------------------------------------------------------------
// mlt_dp
// Datapath: key hash on a shared 32x32 multiplier, bucket memory, way
// compare and update, time keeping and the aging sweep.
// ----------------------------------------------------------------------------
`include "mac_learning_table_top_assert.svh"

module mlt_dp #(
  parameter int BUCKET_BITS = mlt_pkg::BUCKET_BITS_DEF,
  parameter int WAYS        = mlt_pkg::WAYS_DEF,
  parameter int TIME_BITS   = mlt_pkg::TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mlt_pkg::in_item_t    item_i,
  input  mlt_pkg::cfg_t        cfg_i,
  input  mlt_pkg::ctl_cmd_t    cmd_i,
  output mlt_pkg::ctl_status_t status_o,
  output mlt_pkg::out_item_t   result_o,
  output logic                 result_valid_o
);
  import mlt_pkg::*;

  localparam int NROWS = 1 << BUCKET_BITS;
  localparam int WIDX  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W = $clog2(WAYS + 1);

  typedef logic [BUCKET_BITS-1:0] row_t;
  typedef logic [TIME_BITS-1:0]   tm_t;

  // Bucket memory, one row per bucket.
  logic [WAYS-1:0]             val_mem  [NROWS];
  logic [WAYS-1:0][KEY_W-1:0]  key_mem  [NROWS];
  logic [WAYS-1:0][PORT_W-1:0] port_mem [NROWS];
  logic [WAYS-1:0][TIME_BITS-1:0] seen_mem [NROWS];

  logic [WAYS-1:0]                val_rd_q;
  logic [WAYS-1:0][KEY_W-1:0]     key_rd_q;
  logic [WAYS-1:0][PORT_W-1:0]    port_rd_q;
  logic [WAYS-1:0][TIME_BITS-1:0] seen_rd_q;

  in_item_t          item_q;
  logic [KEY_W-1:0]  h_q, h_d, acc_q, acc_d;
  row_t              bucket_q, row_q, row_d, rd_addr, wr_addr;
  tm_t               now_q, now_d, last_q, last_d, now_inc;
  logic [AGED_W-1:0] aged_q, aged_d;
  out_item_t         res_q, res_d;
  logic              res_valid_q;

  // Shared multiplier operands for the hash rounds.
  logic [KEY_W-1:0]  mul_k;
  logic [HALF_W-1:0] mul_x, mul_y;
  logic [KEY_W-1:0]  prod;

  always_comb begin
    mul_k = cmd_i.round ? HASH_MUL_B : HASH_MUL_A;
    mul_x = h_q[HALF_W-1:0];
    mul_y = mul_k[HALF_W-1:0];
    case (cmd_i.hstep)
      HS_MMID: mul_x = h_q[KEY_W-1:HALF_W];
      HS_MHI:  mul_y = mul_k[KEY_W-1:HALF_W];
      default: mul_x = h_q[HALF_W-1:0];
    endcase
    prod = KEY_W'(mul_x) * KEY_W'(mul_y);
  end

  // Hash register: xor-shift, then the low product and two cross terms.
  always_comb begin
    h_d   = h_q;
    acc_d = acc_q;
    if (cmd_i.capture) begin
      h_d = {item_i.vlan, item_i.mac};
    end else begin
      case (cmd_i.hstep)
        HS_XOR:  h_d   = h_q ^ (h_q >> HASH_SHIFT);
        HS_MLO:  acc_d = prod;
        HS_MMID: acc_d = acc_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
        HS_MHI:  h_d   = acc_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
        default: h_d   = h_q;
      endcase
    end
  end

  // Way compare and entry update for lookup and learn.
  logic [KEY_W-1:0]  key_in;
  logic [WAYS-1:0]   match, free;
  logic [WIDX-1:0]   found_idx, free_idx;
  logic              found_any, free_any;
  logic [PORT_W-1:0] old_port;
  tm_t               idle_found;
  logic              is_learn, is_lookup;
  logic [WAYS-1:0]                upd_val;
  logic [WAYS-1:0][KEY_W-1:0]     upd_key;
  logic [WAYS-1:0][PORT_W-1:0]    upd_port;
  logic [WAYS-1:0][TIME_BITS-1:0] upd_seen;
  logic              upd_we;
  out_item_t         upd_res;

  always_comb begin
    key_in    = {item_q.vlan, item_q.mac};
    is_learn  = (item_q.command == CMD_LEARN);
    is_lookup = (item_q.command == CMD_LOOKUP);
    found_idx = '0;
    free_idx  = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      match[w] = val_rd_q[w] && (key_rd_q[w] == key_in);
      free[w]  = !val_rd_q[w];
      if (match[w]) found_idx = WIDX'(w);
      if (free[w])  free_idx  = WIDX'(w);
    end
    found_any  = |match;
    free_any   = |free;
    old_port   = port_rd_q[found_idx];
    idle_found = now_q - seen_rd_q[found_idx];

    upd_val  = val_rd_q;
    upd_key  = key_rd_q;
    upd_port = port_rd_q;
    upd_seen = seen_rd_q;
    upd_we   = 1'b0;
    upd_res  = '0;
    if (is_lookup && found_any) begin
      upd_res.hit      = 1'b1;
      upd_res.port_out = old_port;
    end else if (is_learn) begin
      if (found_any) begin
        upd_res.hit      = 1'b1;
        upd_res.port_out = old_port;
        upd_we           = 1'b1;
        if (old_port != item_q.port) begin
          if (idle_found > tm_t'(cfg_i.move_hold)) begin
            upd_port[found_idx] = item_q.port;
            upd_seen[found_idx] = now_q;
          end
        end else begin
          upd_seen[found_idx] = now_q;
        end
      end else if (free_any) begin
        upd_val[free_idx]  = 1'b1;
        upd_key[free_idx]  = key_in;
        upd_port[free_idx] = item_q.port;
        upd_seen[free_idx] = now_q;
        upd_we             = 1'b1;
        upd_res.port_out   = item_q.port;
      end else begin
        upd_res.status = 1'b1;
      end
    end
  end

  // Aging of one row during a sweep.
  logic [WAYS-1:0]   expired, swp_val;
  logic [CNT_W-1:0]  exp_cnt;
  logic [AGED_W:0]   aged_sum;

  always_comb begin
    exp_cnt = '0;
    for (int w = 0; w < WAYS; w++) begin
      expired[w] = val_rd_q[w] &&
                   ((now_q - seen_rd_q[w]) > tm_t'(cfg_i.expire_age));
      exp_cnt    = exp_cnt + CNT_W'(expired[w]);
    end
    swp_val  = val_rd_q & ~expired;
    aged_sum = {1'b0, aged_q} + (AGED_W + 1)'(exp_cnt);
  end

  // Time keeping and sweep bookkeeping.
  assign now_inc            = now_q + tm_t'(1);
  assign status_o.sweep_due = (tm_t'(now_inc - last_q) > tm_t'(cfg_i.sweep_interval));
  assign status_o.row_last  = (row_q == row_t'(NROWS - 1));

  always_comb begin
    now_d  = now_q;
    last_d = last_q;
    row_d  = row_q;
    aged_d = aged_q;
    if (cmd_i.capture) begin
      row_d  = '0;
      aged_d = '0;
    end
    if (cmd_i.time_tick) begin
      now_d = now_inc;
      if (status_o.sweep_due) last_d = now_inc;
    end
    if (cmd_i.clear_write || cmd_i.sweep_write) row_d = row_q + row_t'(1);
    if (cmd_i.sweep_write) begin
      aged_d = (aged_sum > (AGED_W + 1)'(AGED_MAX)) ? AGED_MAX : aged_sum[AGED_W-1:0];
    end
  end

  // Result register.
  always_comb begin
    res_d = res_q;
    if (cmd_i.entry_update) begin
      res_d = upd_res;
    end else if (cmd_i.emit_tick) begin
      res_d            = '0;
      res_d.aged_count = aged_q;
    end
  end

  assign rd_addr        = cmd_i.mem_read ? h_q[BUCKET_BITS-1:0] : row_q;
  assign wr_addr        = cmd_i.entry_update ? bucket_q : row_q;
  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

  // Memory ports: registered read, row write.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_read || cmd_i.sweep_read) begin
      val_rd_q  <= val_mem[rd_addr];
      key_rd_q  <= key_mem[rd_addr];
      port_rd_q <= port_mem[rd_addr];
      seen_rd_q <= seen_mem[rd_addr];
    end
    if (cmd_i.clear_write) begin
      val_mem[wr_addr] <= '0;
    end else if (cmd_i.sweep_write) begin
      val_mem[wr_addr] <= swp_val;
    end else if (cmd_i.entry_update && upd_we) begin
      val_mem[wr_addr]  <= upd_val;
      key_mem[wr_addr]  <= upd_key;
      port_mem[wr_addr] <= upd_port;
      seen_mem[wr_addr] <= upd_seen;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= item_i;
    if (cmd_i.mem_read) bucket_q <= h_q[BUCKET_BITS-1:0];
    h_q   <= h_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  // Control and time state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      last_q      <= '0;
      row_q       <= '0;
      aged_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      now_q       <= now_d;
      last_q      <= last_d;
      row_q       <= row_d;
      aged_q      <= aged_d;
      res_valid_q <= cmd_i.entry_update || cmd_i.emit_tick;
    end
  end

  // Checks on the result logic.
  `MLT_ASSERT_NEXT(a_single_strobe, res_valid_q, !res_valid_q, "result strobe held twice")
  `MLT_ASSERT_NOW(a_tick_fields, res_valid_q && (res_q.aged_count != '0),
                  !res_q.hit && !res_q.status && (res_q.port_out == '0),
                  "aged result carries lookup fields")
  `MLT_ASSERT_NOW(a_full_no_hit, res_valid_q && res_q.status,
                  !res_q.hit && (res_q.port_out == '0), "full bucket reported with a hit")

endmodule

### tb/mac_learning_table_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mac_learning_table_top_test
// Self-checking bench for the MAC learning table. A behavioral copy of the
// table predicts every result from the accepted commands. The bench runs a
// directed pass over the corner cases, then random traffic over a small key
// pool under several register settings, with random gaps between commands.
// ----------------------------------------------------------------------------
module mac_learning_table_top_test;
  import mlt_pkg::*;

  localparam int NBKT   = 1 << BUCKET_BITS_DEF;
  localparam int NWAY   = WAYS_DEF;
  localparam int NSLOT  = NBKT * NWAY;
  localparam int WDOG   = 5000;
  localparam int POOL_N = 24;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t item_i = '0;
  out_item_t result_o;
  logic result_valid_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  mac_learning_table_top i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the table and its registers.
  logic            tbl_valid [NSLOT];
  logic [63:0]     tbl_key   [NSLOT];
  logic [31:0]     tbl_port  [NSLOT];
  logic [31:0]     tbl_seen  [NSLOT];
  logic [31:0]     now_sec, last_sweep_sec;
  logic [15:0]     persist_reg, expire_reg, sweep_reg;
  out_item_t       pending_results [$];
  int              mismatches, results_seen, items_sent, idle_cycles;
  int              aged_total, full_total, moves_total;
  logic [63:0]     key_pool [POOL_N];

  // Two xor-shift and multiply rounds, masked to a bucket.
  function automatic int bucket_index(logic [63:0] k);
    k = k ^ (k >> HASH_SHIFT);
    k = k * 64'hff51afd7ed558ccd;
    k = k ^ (k >> HASH_SHIFT);
    k = k * 64'hc4ceb9fe1a85ec53;
    return int'(k[BUCKET_BITS_DEF-1:0]);
  endfunction

  // Work out the result of one command and update the shadow table.
  function automatic out_item_t predict_table(in_item_t it);
    out_item_t r;
    logic [63:0] k;
    int base, found, freew, aged;
    r = '0;
    k = {it.vlan, it.mac};
    base = bucket_index(k) * NWAY;
    found = -1;
    freew = -1;
    aged = 0;
    if (it.command == CMD_LOOKUP || it.command == CMD_LEARN) begin
      for (int w = 0; w < NWAY; w++) begin
        if (tbl_valid[base+w]) begin
          if (found < 0 && tbl_key[base+w] == k) found = base + w;
        end else if (freew < 0) begin
          freew = base + w;
        end
      end
    end
    case (it.command)
      CMD_LOOKUP: begin
        if (found >= 0) begin
          r.hit = 1'b1;
          r.port_out = tbl_port[found];
        end
      end
      CMD_LEARN: begin
        if (found >= 0) begin
          r.hit = 1'b1;
          r.port_out = tbl_port[found];
          if (tbl_port[found] != it.port) begin
            if (now_sec - tbl_seen[found] > {16'd0, persist_reg}) begin
              tbl_port[found] = it.port;
              tbl_seen[found] = now_sec;
              moves_total++;
            end
          end else begin
            tbl_seen[found] = now_sec;
          end
        end else if (freew >= 0) begin
          tbl_valid[freew] = 1'b1;
          tbl_key[freew] = k;
          tbl_port[freew] = it.port;
          tbl_seen[freew] = now_sec;
          r.port_out = it.port;
        end else begin
          r.status = 1'b1;
          full_total++;
        end
      end
      CMD_TICK: begin
        now_sec = now_sec + 32'd1;
        if (now_sec - last_sweep_sec > {16'd0, sweep_reg}) begin
          for (int s = 0; s < NSLOT; s++) begin
            if (tbl_valid[s] && (now_sec - tbl_seen[s] > {16'd0, expire_reg})) begin
              tbl_valid[s] = 1'b0;
              aged++;
            end
          end
          last_sweep_sec = now_sec;
        end
        if (aged > 1023) aged = 1023;
        r.aged_count = AGED_W'(aged);
        aged_total += aged;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one command beat; start stays high until the caller idles.
  task automatic send_command(in_item_t it);
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(predict_table(it));
    items_sent++;
  endtask

  // Drop start for a random gap, mostly short.
  task automatic idle_gap();
    int pick, n;
    pick = $urandom_range(99);
    n = (pick < 60) ? 0 : (pick < 92) ? $urandom_range(3, 1) : $urandom_range(40, 10);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Wait until every result is in and the block is idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup beat then access beat.
  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(idx) << 2;
    pwdata <= {16'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MIN_PERSIST: persist_reg = val;
      REG_EXPIRE_AGE:  expire_reg = val;
      REG_SWEEP_INT:   sweep_reg = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [15:0] mp, logic [15:0] ea, logic [15:0] si);
    drain();
    write_reg(REG_MIN_PERSIST, mp);
    write_reg(REG_EXPIRE_AGE, ea);
    write_reg(REG_SWEEP_INT, si);
  endtask

  function automatic in_item_t make_item(cmd_e c, logic [63:0] k, logic [31:0] p);
    in_item_t it;
    it.command = c;
    it.mac = k[47:0];
    it.vlan = k[63:48];
    it.port = p;
    return it;
  endfunction

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Key pool: random keys plus six that share one bucket, so it can fill.
  task automatic build_key_pool();
    logic [63:0] k;
    int target;
    for (int i = 0; i < POOL_N - 6; i++) key_pool[i] = rand_key();
    target = $urandom_range(NBKT - 1);
    for (int i = POOL_N - 6; i < POOL_N; i++) begin
      do k = rand_key(); while (bucket_index(k) != target);
      key_pool[i] = k;
    end
  endtask

  // Corner cases: field extremes, moves inside and outside the hold time,
  // a full bucket, the unused command code and a sweep.
  task automatic test_directed();
    logic [63:0] k0;
    k0 = key_pool[0];
    send_command(make_item(CMD_LOOKUP, '1, '1));
    send_command(make_item(CMD_LEARN, '1, '1));
    send_command(make_item(CMD_LOOKUP, '1, '0));
    send_command(make_item(CMD_LEARN, '0, '0));
    send_command(make_item(CMD_LOOKUP, '0, '1));
    send_command(make_item(CMD_LEARN, k0, 32'h1111_0000));
    send_command(make_item(CMD_LEARN, k0, 32'h2222_0000));
    send_command(make_item(CMD_LEARN, k0, 32'h1111_0000));
    for (int i = 0; i < 4; i++) send_command(make_item(CMD_TICK, '0, '0));
    send_command(make_item(CMD_LEARN, k0, 32'h2222_0000));
    send_command(make_item(CMD_LOOKUP, k0, '0));
    for (int i = POOL_N - 6; i < POOL_N; i++)
      send_command(make_item(CMD_LEARN, key_pool[i], 32'(i)));
    send_command(make_item(CMD_NOP, '1, '1));
    send_command(make_item(CMD_TICK, '1, '1));
    drain();
  endtask

  // Random traffic over the pool, with some noise keys and a pause to drain.
  task automatic test_random(int n);
    logic [63:0] k;
    logic [31:0] p;
    int pick, slot;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      slot = $urandom_range(POOL_N - 1);
      k = ($urandom_range(9) == 0) ? rand_key() : key_pool[slot];
      p = ($urandom_range(3) == 0) ? $urandom() : {28'd0, 2'd0, 2'($urandom_range(1))} + 32'(slot);
      if (pick < 40)      send_command(make_item(CMD_LEARN, k, p));
      else if (pick < 76) send_command(make_item(CMD_LOOKUP, k, $urandom()));
      else if (pick < 96) send_command(make_item(CMD_TICK, rand_key(), $urandom()));
      else                send_command(make_item(CMD_NOP, rand_key(), $urandom()));
      if (i == n / 2) drain();
      else idle_gap();
    end
  endtask

  // Compare each result beat with the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (result_o.hit !== exp_r.hit || result_o.port_out !== exp_r.port_out ||
            result_o.status !== exp_r.status || result_o.aged_count !== exp_r.aged_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", exp_r, result_o);
        end
      end
    end
  end

  // Watchdog on cycles with no beat in either direction.
  always @(posedge clk_i) begin
    if (!rst_ni || result_valid_o || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG) begin
      $display("mac_learning_table_top_test: errors");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < NSLOT; s++) tbl_valid[s] = 1'b0;
    now_sec = '0;
    last_sweep_sec = '0;
    persist_reg = MIN_PERSIST_RST;
    expire_reg = EXPIRE_AGE_RST;
    sweep_reg = SWEEP_INT_RST;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    idle_cycles = 0;
    aged_total = 0;
    full_total = 0;
    moves_total = 0;
    build_key_pool();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(230);
    set_regs(16'd0, 16'd0, 16'd0);
    test_random(230);
    set_regs(16'hffff, 16'hffff, 16'hffff);
    test_random(230);
    set_regs(16'd2, 16'd8, 16'd1);
    test_random(230);
    set_regs(16'($urandom_range(6)), 16'($urandom_range(30)), 16'($urandom_range(4)));
    test_random(230);
    drain();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d commands, checked %0d results (%0d mismatches).",
             items_sent, results_seen, mismatches);
    $display("Port moves %0d, full-bucket refusals %0d, entries aged out %0d.",
             moves_total, full_total, aged_total);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("mac_learning_table_top_test: clean");
    end else begin
      $display("mac_learning_table_top_test: errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/mlt_pkg.sv
design/mlt_cfg.sv
design/mlt_ctrl.sv
design/mlt_dp.sv
design/mac_learning_table_top.sv
tb/mac_learning_table_top_test.sv
